// File: hdl/bqfc_pkg.sv
// ----------------------------------------------------------------------------
// bqfc_pkg: shared types, constants and microcode for the biquad filter
// Holds the control word layout and the sequencer program that runs it.
// ----------------------------------------------------------------------------
`default_nettype none

package bqfc_pkg;

  // Step counter of the microcode sequencer.
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Configuration register indexes, also used to pick a gain for the multiplier.
  localparam int NUM_GAINS = 6;
  localparam int GAIN_IDX_W = 3;
  typedef enum logic [GAIN_IDX_W-1:0] {
    GAIN_FF0 = 3'd0,
    GAIN_FF1 = 3'd1,
    GAIN_FF2 = 3'd2,
    GAIN_FB1 = 3'd3,
    GAIN_FB2 = 3'd4,
    GAIN_RES = 3'd5
  } gain_idx_t;

  localparam logic [31:0] GAIN_RESET [NUM_GAINS] = '{
    32'd16777216, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  // History slot feeding the sample side of the multiplier.
  typedef enum logic [2:0] {
    SRC_X0,
    SRC_X1,
    SRC_X2,
    SRC_Y0,
    SRC_Y1,
    SRC_Y2
  } src_t;

  // Feedback injection stages.
  typedef enum logic [1:0] {
    FB_NONE,
    FB_MAG,
    FB_DIV,
    FB_SUM
  } fb_op_t;

  // Accumulator operations.
  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  // Jump conditions: when true, the sequencer jumps to the target.
  typedef enum logic [1:0] {
    COND_NONE,
    COND_NO_IN,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    cond_t     cond;
    step_t     target;
    logic      accept;
    logic      shift;
    src_t      src;
    gain_idx_t coef;
    logic      hi;
    fb_op_t    fb_op;
    acc_op_t   acc_op;
    logic      done;
  } ctrl_t;

  // Feedback and history limits in Q.16.
  localparam int unsigned FB_LIMIT = 294912;      // 4.5
  localparam int unsigned FB_CLAMP = 327680;      // 5.0
  localparam int unsigned FB_DIV_SAT = 3276800;   // magnitudes at or above clamp after /10
  localparam int unsigned HIST_CLAMP = 6553600;   // 100.0

  // Reciprocal of ten for magnitudes below 2^22: q = (m * K) >> 28.
  localparam int FB_MAG_W = 19;
  localparam int DIV_IN_W = 22;
  localparam int DIV_SHIFT = 28;
  localparam logic [24:0] DIV10_K = 25'd26843546;

  function automatic ctrl_t mk(input cond_t c, input step_t t, input logic acc_in,
                               input logic sh, input src_t s, input gain_idx_t g,
                               input logic h, input fb_op_t f, input acc_op_t a,
                               input logic d);
    ctrl_t w;
    w.cond   = c;
    w.target = t;
    w.accept = acc_in;
    w.shift  = sh;
    w.src    = s;
    w.coef   = g;
    w.hi     = h;
    w.fb_op  = f;
    w.acc_op = a;
    w.done   = d;
    return w;
  endfunction

  // The program. Each product takes a high-half and a low-half multiply step;
  // the two half products pass through mreg and hreg and recombine into term.
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    case (step)
      4'd0:  w = mk(COND_NO_IN, 4'd0, 1'b1, 1'b0, SRC_X0, GAIN_FF0, 1'b0, FB_NONE, ACC_NONE,
                    1'b0);
      4'd1:  w = mk(COND_NONE, 4'd0, 1'b0, 1'b1, SRC_Y0, GAIN_RES, 1'b1, FB_NONE, ACC_NONE,
                    1'b0);
      4'd2:  w = mk(COND_NONE, 4'd0, 1'b0, 1'b0, SRC_Y0, GAIN_RES, 1'b0, FB_NONE, ACC_NONE,
                    1'b0);
      4'd3:  w = mk(COND_NONE, 4'd0, 1'b0, 1'b0, SRC_X1, GAIN_FF1, 1'b1, FB_NONE, ACC_NONE,
                    1'b0);
      4'd4:  w = mk(COND_NONE, 4'd0, 1'b0, 1'b0, SRC_X1, GAIN_FF1, 1'b0, FB_MAG, ACC_NONE,
                    1'b0);
      4'd5:  w = mk(COND_NONE, 4'd0, 1'b0, 1'b0, SRC_X2, GAIN_FF2, 1'b1, FB_DIV, ACC_NONE,
                    1'b0);
      4'd6:  w = mk(COND_NONE, 4'd0, 1'b0, 1'b0, SRC_X2, GAIN_FF2, 1'b0, FB_SUM, ACC_LOAD,
                    1'b0);
      4'd7:  w = mk(COND_NONE, 4'd0, 1'b0, 1'b0, SRC_Y1, GAIN_FB1, 1'b1, FB_NONE, ACC_NONE,
                    1'b0);
      4'd8:  w = mk(COND_NONE, 4'd0, 1'b0, 1'b0, SRC_Y1, GAIN_FB1, 1'b0, FB_NONE, ACC_ADD,
                    1'b0);
      4'd9:  w = mk(COND_NONE, 4'd0, 1'b0, 1'b0, SRC_Y2, GAIN_FB2, 1'b1, FB_NONE, ACC_NONE,
                    1'b0);
      4'd10: w = mk(COND_NONE, 4'd0, 1'b0, 1'b0, SRC_Y2, GAIN_FB2, 1'b0, FB_NONE, ACC_SUB,
                    1'b0);
      4'd11: w = mk(COND_NONE, 4'd0, 1'b0, 1'b0, SRC_X0, GAIN_FF0, 1'b1, FB_NONE, ACC_NONE,
                    1'b0);
      4'd12: w = mk(COND_NONE, 4'd0, 1'b0, 1'b0, SRC_X0, GAIN_FF0, 1'b0, FB_NONE, ACC_SUB,
                    1'b0);
      4'd13: w = mk(COND_NONE, 4'd0, 1'b0, 1'b0, SRC_X0, GAIN_FF0, 1'b0, FB_NONE, ACC_NONE,
                    1'b0);
      4'd14: w = mk(COND_NONE, 4'd0, 1'b0, 1'b0, SRC_X0, GAIN_FF0, 1'b0, FB_NONE, ACC_ADD,
                    1'b0);
      4'd15: w = mk(COND_OUT_BUSY, 4'd15, 1'b0, 1'b0, SRC_X0, GAIN_FF0, 1'b0, FB_NONE,
                    ACC_NONE, 1'b1);
      default: w = mk(COND_NONE, 4'd0, 1'b0, 1'b0, SRC_X0, GAIN_FF0, 1'b0, FB_NONE, ACC_NONE,
                      1'b0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hdl/bqfc_seq.sv
// ----------------------------------------------------------------------------
// bqfc_seq: microcode sequencer
// Step counter, program table lookup and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module bqfc_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            out_busy,
  output bqfc_pkg::ctrl_t      ctrl,
  output logic                 advance
);

  bqfc_pkg::step_t step;
  bqfc_pkg::step_t step_next;
  logic            jump;

  assign ctrl = bqfc_pkg::ucode(step);

  always_comb begin
    case (ctrl.cond)
      bqfc_pkg::COND_NONE:     jump = 1'b0;
      bqfc_pkg::COND_NO_IN:    jump = !in_valid;
      bqfc_pkg::COND_OUT_BUSY: jump = out_busy;
      default:                 jump = 1'b0;
    endcase
  end

  // The counter wraps from the last step back to the idle step.
  assign step_next = jump ? ctrl.target : step + bqfc_pkg::step_t'(1);
  assign advance   = !jump;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/biquad_with_feedback_clip.sv
// ----------------------------------------------------------------------------
// biquad_with_feedback_clip: direct form I biquad with clipped resonance feedback
// Top level: configuration gains, history, shared multiplier and sequencer.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the sample_in channel (in_valid / in_ready) and one filtered
// sample leaves on the sample_out channel (out_valid / out_ready) per request.
// Samples are signed with 16 fraction bits; gains are signed Q8.24 and are
// written through cfg_write / cfg_index / cfg_data while the filter is idle.
// Indexes beyond the last gain are ignored.
// A request is taken only in the idle step of the sequencer. The program then
// runs its remaining steps on one shared multiplier: six products, each split
// into a high-half and a low-half multiply, plus the feedback clip and the
// final saturation. The result is valid once the last step completes, and no
// new request is taken until the sequencer is back in its idle step, since the
// single multiplier handles every product of the program in turn.
// The result sits in an output register, so the filter returns to idle and
// takes the next input while an earlier result waits. If the receiver stalls
// and the output register is still full when the next result is ready, the
// sequencer holds on its last step until the register frees up.
// Reset restores the default gains (unity pass-through), clears all history
// and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_with_feedback_clip #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
  input  wire logic                           cfg_write,
  input  wire logic [2:0]                     cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int XW = SAMPLE_WIDTH + 16;  // extended width for sums and limits
  localparam int PW = SAMPLE_WIDTH + 17;  // half-product width
  localparam int FW = SAMPLE_WIDTH + 33;  // recombined full product width
  localparam int MW = bqfc_pkg::FB_MAG_W;

  localparam logic signed [XW-1:0] SMAX = $signed((XW'(1) << (W - 1)) - XW'(1));
  localparam logic signed [XW-1:0] SMIN = -SMAX - XW'(1);
  localparam logic signed [XW-1:0] HMAX = $signed(XW'(bqfc_pkg::HIST_CLAMP));
  localparam logic signed [XW-1:0] HMIN = -HMAX;

  // Saturate an extended value to the sample range.
  function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
    logic signed [W-1:0] r;
    if (v > SMAX) begin
      r = W'(SMAX);
    end else if (v < SMIN) begin
      r = W'(SMIN);
    end else begin
      r = W'(v);
    end
    return r;
  endfunction

  // Clamp a history sample to plus or minus 100.0. At narrow widths the bound
  // lies beyond the sample range and the clamp never fires.
  function automatic logic signed [W-1:0] clamp_h(input logic signed [W-1:0] v);
    logic signed [XW-1:0] e;
    logic signed [W-1:0]  r;
    e = XW'(v);
    if (e > HMAX) begin
      r = W'(HMAX);
    end else if (e < HMIN) begin
      r = W'(HMIN);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Sequencer.
  bqfc_pkg::ctrl_t ctrl;
  logic            advance;
  logic            out_busy;

  assign out_busy = out_valid && !out_ready;

  bqfc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .ctrl     (ctrl),
    .advance  (advance)
  );

  assign in_ready = ctrl.accept;

  // Gain registers.
  logic [31:0] gain [bqfc_pkg::NUM_GAINS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bqfc_pkg::NUM_GAINS; i++) begin
        gain[i] <= bqfc_pkg::GAIN_RESET[i];
      end
    end else if (cfg_write && cfg_index <= 3'(bqfc_pkg::GAIN_RES)) begin
      gain[cfg_index] <= cfg_data;
    end
  end

  // Input and output history.
  logic signed [W-1:0] xin;
  logic signed [W-1:0] x0, x1, x2;
  logic signed [W-1:0] y0, y1, y2;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      xin <= sample_in;
    end
  end

  // Shared multiplier: sample times the signed high half or the unsigned low
  // half of a gain, registered, with the previous half product kept behind it.
  logic signed [W-1:0]  mul_s;
  logic [31:0]          mul_c;
  logic signed [16:0]   mul_c17;
  logic signed [PW-1:0] mul_p;
  logic signed [PW-1:0] mreg;
  logic signed [PW-1:0] hreg;
  logic signed [FW-1:0] comb_full;
  logic signed [XW-1:0] term;

  always_comb begin
    case (ctrl.src)
      bqfc_pkg::SRC_X0: mul_s = x0;
      bqfc_pkg::SRC_X1: mul_s = x1;
      bqfc_pkg::SRC_X2: mul_s = x2;
      bqfc_pkg::SRC_Y0: mul_s = y0;
      bqfc_pkg::SRC_Y1: mul_s = y1;
      bqfc_pkg::SRC_Y2: mul_s = y2;
      default:          mul_s = x0;
    endcase
  end

  assign mul_c   = gain[ctrl.coef];
  assign mul_c17 = ctrl.hi ? $signed({mul_c[31], mul_c[31:16]})
                           : $signed({1'b0, mul_c[15:0]});
  assign mul_p   = PW'(mul_s) * PW'(mul_c17);

  // Exact product rebuilt from the halves, then floored by 2^24.
  assign comb_full = (FW'(hreg) <<< 16) + FW'(mreg);

  always_ff @(posedge clk) begin
    mreg <= mul_p;
    hreg <= mreg;
    term <= XW'(comb_full >>> 24);
  end

  // Feedback clip. The magnitude above 4.5 is divided by ten, truncating, and
  // limited to 5.0; anything that would divide to more than 5.0 goes straight
  // to the limit, so the divider only sees magnitudes below 2^22.
  logic                  fb_neg;
  logic [XW-1:0]         fb_mag;
  logic [MW-1:0]         fbm;
  logic [46:0]           div_p;
  logic signed [XW-1:0]  fb_ext;
  logic signed [XW-1:0]  fb_val;
  logic signed [XW-1:0]  x_sum;

  assign div_p  = 47'(fb_mag[bqfc_pkg::DIV_IN_W-1:0]) * 47'(bqfc_pkg::DIV10_K);
  assign fb_ext = $signed(XW'(fbm));
  assign fb_val = fb_neg ? -fb_ext : fb_ext;
  assign x_sum  = XW'(xin) + fb_val;

  always_ff @(posedge clk) begin
    case (ctrl.fb_op)
      bqfc_pkg::FB_MAG: begin
        fb_neg <= term[XW-1];
        fb_mag <= term[XW-1] ? unsigned'(-term) : unsigned'(term);
      end
      bqfc_pkg::FB_DIV: begin
        if (fb_mag >= XW'(bqfc_pkg::FB_DIV_SAT)) begin
          fbm <= MW'(bqfc_pkg::FB_CLAMP);
        end else if (fb_mag > XW'(bqfc_pkg::FB_LIMIT)) begin
          fbm <= div_p[bqfc_pkg::DIV_SHIFT+MW-1:bqfc_pkg::DIV_SHIFT];
        end else begin
          fbm <= fb_mag[MW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Accumulator for the five-tap sum.
  logic signed [XW-1:0] acc;

  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      bqfc_pkg::ACC_LOAD: acc <= term;
      bqfc_pkg::ACC_ADD:  acc <= acc + term;
      bqfc_pkg::ACC_SUB:  acc <= acc - term;
      default:            acc <= acc;
    endcase
  end

  // History update: the older slots shift with the clamp at the start of the
  // program, the new input lands once the feedback is known, and the new
  // output at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      x0 <= '0;
      x1 <= '0;
      x2 <= '0;
      y0 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else begin
      if (ctrl.shift) begin
        x2 <= clamp_h(x1);
        x1 <= clamp_h(x0);
        y2 <= clamp_h(y1);
        y1 <= clamp_h(y0);
      end
      if (ctrl.fb_op == bqfc_pkg::FB_SUM) begin
        x0 <= sat_w(x_sum);
      end
      if (ctrl.done && advance) begin
        y0 <= sat_w(acc);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.done && advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done && advance) begin
      sample_out <= sat_w(acc);
    end
  end

`ifndef SYNTHESIS
  // Once a request is taken the program runs and cannot take another at once.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

  // A new result only appears from the completion step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.done && advance))
    else $error("result appeared outside the completion step");

  // The clipped feedback magnitude never exceeds 5.0.
  assert property (@(posedge clk) disable iff (rst)
    $past(ctrl.fb_op == bqfc_pkg::FB_DIV) |-> (fbm <= MW'(bqfc_pkg::FB_CLAMP)))
    else $error("feedback magnitude beyond clamp");

  // Shifted history stays within plus or minus 100.0.
  assert property (@(posedge clk) disable iff (rst)
    (XW'(x1) <= HMAX) && (XW'(x1) >= HMIN) && (XW'(y2) <= HMAX) && (XW'(y2) >= HMIN))
    else $error("history beyond clamp");
`endif

endmodule

`default_nettype wire

// File: sim/tb_biquad_with_feedback_clip.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_biquad_with_feedback_clip: self-checking bench for the feedback biquad
// A directed table walks the sample extremes, the feedback clip and divide,
// the history clamp and the output saturation, and the ignored register
// indexes. Random traffic with changing gains and handshake pressure follows.
// Results are checked against an in-bench fixed-point model or a pinned value.
// ----------------------------------------------------------------------------
module tb_biquad_with_feedback_clip;

  localparam int SAMPLE_W = 32;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Fixed-point limits in Q.16, and the product shift for Q8.24 gains.
  localparam int     FRAC_BITS      = 24;
  localparam longint FB_LIMIT_Q16   = 294912;   // 4.5
  localparam longint FB_CLAMP_Q16   = 327680;   // 5.0
  localparam longint HIST_CLAMP_Q16 = 6553600;  // 100.0
  localparam longint SAMPLE_MAX     = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN     = -SAMPLE_MAX - 1;
  localparam logic [31:0] UNITY_GAIN = 32'h0100_0000;

  // Register indexes past the last gain; writes to them must be dropped.
  localparam logic [2:0] CFG_SPARE_6 = 3'd6;
  localparam logic [2:0] CFG_SPARE_7 = 3'd7;

  // Settling time after the last result, so the sequencer is back in its idle step.
  localparam int SETTLE_CYCLES  = 24;
  localparam int PRESSURE_HOLD  = 300;
  // Longest legal quiet stretch is the pressure hold; allow several times it.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED    = 40;

  localparam int NUM_RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE   = 85;

  typedef enum logic [2:0] {
    TRAFFIC_FREE,
    TRAFFIC_SEND_IDLE,
    TRAFFIC_RECV_STALL,
    TRAFFIC_BOTH,
    TRAFFIC_PRESSURE
  } traffic_t;

  localparam traffic_t PHASE_PLAN [NUM_RANDOM_PHASES] = '{
    TRAFFIC_FREE, TRAFFIC_SEND_IDLE, TRAFFIC_RECV_STALL, TRAFFIC_BOTH,
    TRAFFIC_PRESSURE, TRAFFIC_SEND_IDLE, TRAFFIC_RECV_STALL, TRAFFIC_BOTH
  };

  // Directed stimulus table. A write row programs one register; a sample row
  // is checked against the model, a pinned row against the value typed in.
  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_SAMPLE,
    ROW_PINNED
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  index;
    logic [31:0] value;
    logic [31:0] result;
  } stim_row_t;

  localparam int NUM_DIRECTED = 44;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // Right after reset: spare indexes must not disturb the unity default.
    '{ROW_WRITE,  CFG_SPARE_6, 32'hdead_beef, 32'h0},
    '{ROW_WRITE,  CFG_SPARE_7, 32'h1234_5678, 32'h0},
    // Unity pass-through with no feedback: output equals input exactly.
    '{ROW_PINNED, 3'd0, 32'h0000_0000, 32'h0000_0000},
    '{ROW_PINNED, 3'd0, 32'h7fff_ffff, 32'h7fff_ffff},
    '{ROW_PINNED, 3'd0, 32'h8000_0000, 32'h8000_0000},
    '{ROW_PINNED, 3'd0, 32'h0000_0001, 32'h0000_0001},
    '{ROW_PINNED, 3'd0, 32'hffff_ffff, 32'hffff_ffff},
    '{ROW_PINNED, 3'd0, 32'h0001_0000, 32'h0001_0000},
    '{ROW_PINNED, 3'd0, 32'haaaa_aaaa, 32'haaaa_aaaa},
    '{ROW_PINNED, 3'd0, 32'h5555_5555, 32'h5555_5555},
    // Full feedforward, recursion and a huge resonance scale: the feedback
    // product overflows 32 bits, the input sum saturates, history clamps.
    '{ROW_WRITE,  bqfc_pkg::GAIN_FF0, UNITY_GAIN,    32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_FF1, UNITY_GAIN,    32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_FF2, UNITY_GAIN,    32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_FB1, 32'h0080_0000, 32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_FB2, 32'hffc0_0000, 32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_RES, 32'h7fff_ffff, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'h7fff_ffff, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'h7fff_ffff, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'h8000_0000, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'h8000_0000, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'h0008_0000, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'hfff8_0000, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'h0000_c000, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'hffff_4000, 32'h0},
    // Feedback near minus one: the divide by ten truncates toward zero, and
    // an output of exactly 4.5 sits on the magnitude threshold.
    '{ROW_WRITE,  bqfc_pkg::GAIN_FF0, UNITY_GAIN,    32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_FF1, 32'h0000_0000, 32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_FF2, 32'h0000_0000, 32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_FB1, 32'h0000_0000, 32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_FB2, 32'h0000_0000, 32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_RES, 32'hff00_0001, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'h0007_4ccd, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'hfff8_b333, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'h0004_8000, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'h0013_0000, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'hffec_0000, 32'h0},
    // Most negative gains everywhere: the five-term sum saturates.
    '{ROW_WRITE,  bqfc_pkg::GAIN_FF0, 32'h8000_0000, 32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_FF1, 32'h8000_0000, 32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_FF2, 32'h8000_0000, 32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_FB1, 32'h8000_0000, 32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_FB2, 32'h8000_0000, 32'h0},
    '{ROW_WRITE,  bqfc_pkg::GAIN_RES, 32'h8000_0000, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'h7fff_ffff, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'h8000_0000, 32'h0},
    '{ROW_SAMPLE, 3'd0, 32'h0010_0000, 32'h0}
  };

  // Block ports. Everything the bench drives starts at a known value.
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  sample_t     sample_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  sample_t     sample_out;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  // Pinned expectation that travels with the sample on offer.
  logic    pin_known = 1'b0;
  sample_t pin_value = '0;

  traffic_t traffic   = TRAFFIC_FREE;
  int       phase_num = 0;

  // Model state: gains as last written, and the two histories.
  int     gain_shadow [bqfc_pkg::NUM_GAINS] = '{32'h0100_0000, 0, 0, 0, 0, 0};
  longint x_hist [3] = '{0, 0, 0};
  longint y_hist [3] = '{0, 0, 0};

  sample_t expected_samples [$];
  int      error_count  = 0;
  int      quiet_cycles = 0;

  // Receiver hold-off bookkeeping, owned by the receiver process.
  int hold_left  = 0;
  int held_phase = 0;

  biquad_with_feedback_clip #(
    .SAMPLE_WIDTH(SAMPLE_W)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point model of one filter step
  // ---------------------------------------------------------------------------

  // Exact product of a Q.16 sample and a Q8.24 gain, floored back to Q.16.
  // Both operands fit in 32 bits, so the 64-bit product never overflows.
  function automatic longint q24_product(input longint s, input longint c);
    return (s * c) >>> FRAC_BITS;
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint saturate(input longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  function automatic sample_t predict_filter_output(input sample_t din);
    longint inject;
    longint acc;
    // The feedback term is tested at full precision; a large one is cut to a
    // tenth (signed division truncates toward zero) and then clamped to 5.
    inject = q24_product(y_hist[0], gain_shadow[bqfc_pkg::GAIN_RES]);
    if (inject > FB_LIMIT_Q16 || inject < -FB_LIMIT_Q16) inject = inject / 10;
    inject = clip(inject, FB_CLAMP_Q16);
    // Histories shift; entries leaving the newest two slots are clamped.
    x_hist[2] = clip(x_hist[1], HIST_CLAMP_Q16);
    x_hist[1] = clip(x_hist[0], HIST_CLAMP_Q16);
    x_hist[0] = saturate(longint'(din) + inject);
    y_hist[2] = clip(y_hist[1], HIST_CLAMP_Q16);
    y_hist[1] = clip(y_hist[0], HIST_CLAMP_Q16);
    // Five floored products summed exactly, saturated once.
    acc = q24_product(x_hist[0], gain_shadow[bqfc_pkg::GAIN_FF0])
        + q24_product(x_hist[1], gain_shadow[bqfc_pkg::GAIN_FF1])
        + q24_product(x_hist[2], gain_shadow[bqfc_pkg::GAIN_FF2])
        - q24_product(y_hist[1], gain_shadow[bqfc_pkg::GAIN_FB1])
        - q24_product(y_hist[2], gain_shadow[bqfc_pkg::GAIN_FB2]);
    y_hist[0] = saturate(acc);
    return sample_t'(y_hist[0]);
  endfunction

  // ---------------------------------------------------------------------------
  // Random picks
  // ---------------------------------------------------------------------------

  // Gains: mostly within +/-1.0 so the filter stays lively without pinning
  // at the rails, with the extremes and fully random patterns mixed in.
  function automatic logic [31:0] pick_gain();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3, 4, 5, 6: return 32'($urandom_range(32'h0200_0000)) - UNITY_GAIN;
      default: return $urandom;
    endcase
  endfunction

  // Samples: small values keep the feedback near its thresholds, medium and
  // full-range values reach the history clamp and the saturation.
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return sample_t'(SAMPLE_MAX);
      1: return sample_t'(SAMPLE_MIN);
      2, 3, 4, 5: return sample_t'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      6, 7: return sample_t'($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus tasks
  // ---------------------------------------------------------------------------

  task automatic log_failure(input string msg);
    if (error_count < MAX_PRINTED) $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  // Writes take effect at the next edge. The enable is left high so that back
  // to back writes need no toggle; the next sample or pause lowers it.
  task automatic write_gain(input logic [2:0] idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Offer one sample request and return at the edge that accepts it. Valid
  // stays high afterwards, so a following request needs no toggle.
  task automatic offer_sample(input sample_t s, input logic pinned, input sample_t pinned_val);
    int idle_pct;
    case (traffic)
      TRAFFIC_SEND_IDLE: idle_pct = 73;
      TRAFFIC_BOTH:      idle_pct = 35;
      default:           idle_pct = 0;
    endcase
    cfg_write <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    pin_known <= pinned;
    pin_value <= pinned_val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering, wait for every pending result, then give the sequencer
  // time to come back to its idle step before any register is touched. The
  // first edge lets the scoreboard log the request taken at the last edge.
  task automatic quiesce();
    in_valid  <= 1'b0;
    cfg_write <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls by phase, plus one long hold-off in the pressure
  // phase so the output register fills and the input side backs up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (traffic == TRAFFIC_PRESSURE && held_phase != phase_num) begin
      out_ready  <= 1'b0;
      hold_left  <= PRESSURE_HOLD;
      held_phase <= phase_num;
    end else begin
      case (traffic)
        TRAFFIC_RECV_STALL: out_ready <= ($urandom_range(99) >= 73);
        TRAFFIC_BOTH:       out_ready <= ($urandom_range(99) >= 35);
        default:            out_ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard. Results are retired before new requests are modeled, so the
  // outcome never depends on process order within an edge. Register writes
  // update the model gains as the block sees them; spare indexes are ignored.
  // The watchdog counts edges with no handshake and no write at all.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic    moved;
    sample_t want;
    sample_t modeled;
    if (!rst) begin
      moved = 1'b0;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (expected_samples.size() == 0) begin
          log_failure($sformatf("sample_out 0x%08h with no request pending", sample_out));
        end else begin
          want = expected_samples.pop_front();
          if (sample_out !== want)
            log_failure($sformatf("sample_out got 0x%08h (%0d), expected 0x%08h (%0d)",
                                  sample_out, sample_out, want, want));
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        // The model always runs so its history follows the block, even when
        // the row carries a value typed in by hand.
        modeled = predict_filter_output(sample_in);
        expected_samples.push_back(pin_known ? pin_value : modeled);
      end
      if (cfg_write) begin
        moved = 1'b1;
        if (cfg_index < bqfc_pkg::NUM_GAINS) gain_shadow[cfg_index] = cfg_data;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] ERROR: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, the directed table, then random phases that each
  // reprogram every gain (and poke a spare index) while the filter is idle.
  // ---------------------------------------------------------------------------
  initial begin
    logic      streaming;
    stim_row_t row;
    streaming = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // A run of writes only starts once the previous samples have drained.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_WRITE) begin
        if (streaming) quiesce();
        streaming = 1'b0;
        write_gain(row.index, row.value);
      end else begin
        offer_sample(sample_t'(row.value), row.kind == ROW_PINNED, sample_t'(row.result));
        streaming = 1'b1;
      end
    end

    for (int p = 0; p < NUM_RANDOM_PHASES; p++) begin
      quiesce();
      traffic   <= PHASE_PLAN[p];
      phase_num <= p + 1;
      for (int g = 0; g < bqfc_pkg::NUM_GAINS; g++) write_gain(3'(g), pick_gain());
      write_gain($urandom_range(1) ? CFG_SPARE_7 : CFG_SPARE_6, $urandom);
      repeat (ITEMS_PER_PHASE) offer_sample(pick_sample(), 1'b0, '0);
    end

    quiesce();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
